FILE: hdl/generator_fifo_timing_device_assert.svh
// ----------------------------------------------------------------------------
// generator fifo timing device - assertion macros
// shared property shapes for the controller and datapath checks
// ----------------------------------------------------------------------------
`ifndef GENERATOR_FIFO_TIMING_DEVICE_ASSERT_SVH
`define GENERATOR_FIFO_TIMING_DEVICE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define GFTD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define GFTD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/gftd_pkg.sv
// ----------------------------------------------------------------------------
// gftd_pkg
// types, codes and constants shared by the generator fifo timing device
// ----------------------------------------------------------------------------
package gftd_pkg;

	// default width of the internal cycle arithmetic
	localparam int CYCLE_WIDTH_DEF = 48;
	// width of the cycle fields on the ports
	localparam int PORT_CYCLE_WIDTH = 48;
	// quotient bits of one catch-up division (at most a full fifo)
	localparam int QUO_WIDTH = 16;

	localparam int ADDR_WIDTH  = 32;
	localparam int CAP_WIDTH   = 16;
	localparam int GCOST_WIDTH = 16;
	localparam int ACOST_WIDTH = 8;
	localparam int STALL_WIDTH = 16;
	localparam int KIND_WIDTH  = 3;
	localparam int CFG_IDX_WIDTH  = 3;
	localparam int CFG_DATA_WIDTH = 32;

	// access kinds
	localparam logic ACTION_READ  = 1'b0;
	localparam logic ACTION_WRITE = 1'b1;

	// result kinds
	localparam logic [KIND_WIDTH-1:0] KIND_REG_READ  = 3'd0;
	localparam logic [KIND_WIDTH-1:0] KIND_DATA_READ = 3'd1;
	localparam logic [KIND_WIDTH-1:0] KIND_START     = 3'd2;
	localparam logic [KIND_WIDTH-1:0] KIND_STOP      = 3'd3;
	localparam logic [KIND_WIDTH-1:0] KIND_SEED      = 3'd4;
	localparam logic [KIND_WIDTH-1:0] KIND_ERROR     = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_WIDTH-1:0] REG_START_ADDRESS  = 3'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_STOP_ADDRESS   = 3'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_SEED_ADDRESS   = 3'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_WINDOW_START   = 3'd3;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_WINDOW_END     = 3'd4;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_FIFO_CAPACITY  = 3'd5;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_GENERATE_COST  = 3'd6;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_ACCESS_COST    = 3'd7;

	// configuration reset values
	localparam logic [ADDR_WIDTH-1:0]  RST_START_ADDRESS = 32'd0;
	localparam logic [ADDR_WIDTH-1:0]  RST_STOP_ADDRESS  = 32'd1;
	localparam logic [ADDR_WIDTH-1:0]  RST_SEED_ADDRESS  = 32'd2;
	localparam logic [ADDR_WIDTH-1:0]  RST_WINDOW_START  = 32'd16;
	localparam logic [ADDR_WIDTH-1:0]  RST_WINDOW_END    = 32'd32;
	localparam logic [CAP_WIDTH-1:0]   RST_FIFO_CAPACITY = 16'd0;
	localparam logic [GCOST_WIDTH-1:0] RST_GENERATE_COST = 16'd1;
	localparam logic [ACOST_WIDTH-1:0] RST_ACCESS_COST   = 8'd1;

	// one bus access
	typedef struct packed {
		logic                        action;
		logic [ADDR_WIDTH-1:0]       address;
		logic [PORT_CYCLE_WIDTH-1:0] now_cycle;
	} request_t;

	// one timing result
	typedef struct packed {
		logic [KIND_WIDTH-1:0]       kind;
		logic [ACOST_WIDTH-1:0]      cost_cycles;
		logic [STALL_WIDTH-1:0]      wait_cycles;
		logic                        generated_on_demand;
		logic [PORT_CYCLE_WIDTH-1:0] ready_at_cycle;
	} result_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic decode;
		logic prep;
		logic cmp;
		logic div_step;
		logic mul;
		logic add;
		logic read;
		logic fix;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [KIND_WIDTH-1:0] kind;
		logic                  catch_up;
		logic                  div_skip;
	} status_t;

endpackage

FILE: hdl/gftd_ctrl.sv
// ----------------------------------------------------------------------------
// gftd_ctrl
// sequencer: decode, catch-up division steps, data read and result strobe
// ----------------------------------------------------------------------------
`include "generator_fifo_timing_device_assert.svh"

module gftd_ctrl import gftd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	output logic    result_valid,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_PREP   = 4'd2;
	localparam logic [3:0] S_CMP    = 4'd3;
	localparam logic [3:0] S_DIV    = 4'd4;
	localparam logic [3:0] S_MUL    = 4'd5;
	localparam logic [3:0] S_ADD    = 4'd6;
	localparam logic [3:0] S_READ   = 4'd7;
	localparam logic [3:0] S_FIX    = 4'd8;
	localparam logic [3:0] S_DONE   = 4'd9;

	localparam int CNT_WIDTH = $clog2(QUO_WIDTH);

	logic [3:0]           state_q;
	logic [3:0]           state_d;
	logic [CNT_WIDTH-1:0] cnt_q;
	logic                 accept;

	// a new transfer may enter while the previous result is strobed
	assign busy         = (state_q != S_IDLE) && (state_q != S_DONE);
	assign result_valid = (state_q == S_DONE);
	assign accept       = start && !busy;

	// commands follow the state
	always_comb begin
		cmd          = '0;
		cmd.load     = accept;
		cmd.decode   = (state_q == S_DECODE);
		cmd.prep     = (state_q == S_PREP);
		cmd.cmp      = (state_q == S_CMP);
		cmd.div_step = (state_q == S_DIV);
		cmd.mul      = (state_q == S_MUL);
		cmd.add      = (state_q == S_ADD);
		cmd.read     = (state_q == S_READ);
		cmd.fix      = (state_q == S_FIX);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE, S_DONE: begin
				state_d = accept ? S_DECODE : S_IDLE;
			end
			S_DECODE: begin
				if (status.kind != KIND_DATA_READ) begin
					state_d = S_DONE;
				end else if (status.catch_up) begin
					state_d = S_PREP;
				end else begin
					state_d = S_READ;
				end
			end
			S_PREP: state_d = S_CMP;
			S_CMP:  state_d = status.div_skip ? S_MUL : S_DIV;
			S_DIV: begin
				if (cnt_q == '0) begin
					state_d = S_MUL;
				end
			end
			S_MUL:  state_d = S_ADD;
			S_ADD:  state_d = S_READ;
			S_READ: state_d = S_FIX;
			S_FIX:  state_d = S_DONE;
			default: state_d = S_IDLE;
		endcase
	end

	// state and division step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CMP) begin
				cnt_q <= CNT_WIDTH'(QUO_WIDTH - 1);
			end else if (state_q == S_DIV) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`GFTD_ASSERT_NXT(a_accept_decodes, accept, state_q == S_DECODE, "accepted transfer not decoded")
	`GFTD_ASSERT_NXT(a_strobe_single, result_valid, !result_valid, "result strobe held too long")
	`GFTD_ASSERT_NXT(a_div_enter, (state_q == S_CMP) && !status.div_skip, (state_q == S_DIV) && (cnt_q == CNT_WIDTH'(QUO_WIDTH - 1)), "division not started")
	`GFTD_ASSERT_NXT(a_div_leave, (state_q == S_DIV) && (cnt_q == '0), state_q == S_MUL, "division overran")

endmodule

FILE: hdl/gftd_datapath.sv
// ----------------------------------------------------------------------------
// gftd_datapath
// configuration, fifo fill state, catch-up divider and result registers
// ----------------------------------------------------------------------------
`include "generator_fifo_timing_device_assert.svh"

module gftd_datapath import gftd_pkg::*; #(
	parameter int CYCLE_WIDTH = CYCLE_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0] cfg_data,
	input  request_t                  request,
	input  cmd_t                      cmd,
	output status_t                   status,
	output result_t                   result
);

	localparam int PROD_WIDTH = QUO_WIDTH + GCOST_WIDTH;

	// configuration
	logic [ADDR_WIDTH-1:0]  start_addr_q, stop_addr_q, seed_reg_q;
	logic [ADDR_WIDTH-1:0]  win_start_q, win_end_q;
	logic [CAP_WIDTH-1:0]   cap_q;
	logic [GCOST_WIDTH-1:0] gcost_q;
	logic [ACOST_WIDTH-1:0] acost_q;

	// generator state
	logic [CAP_WIDTH-1:0]   held_q;
	logic [CYCLE_WIDTH-1:0] lgc_q;
	logic                   running_q;
	logic                   pause_q;

	// latched access
	logic                   act_q;
	logic [ADDR_WIDTH-1:0]  addr_q;
	logic [CYCLE_WIDTH-1:0] now_q;

	// catch-up working registers
	logic [CAP_WIDTH-1:0]   room_q;
	logic [CYCLE_WIDTH-1:0] elapsed_q;
	logic [PROD_WIDTH-1:0]  lim_q;
	logic [PROD_WIDTH-1:0]  rem_q;
	logic [PROD_WIDTH-1:0]  dsr_q;
	logic [QUO_WIDTH-1:0]   n_q;
	logic [PROD_WIDTH-1:0]  nprod_q;
	logic                   fix_q;

	// result registers
	logic [KIND_WIDTH-1:0]  kind_q;
	logic [ACOST_WIDTH-1:0] cost_q;
	logic [STALL_WIDTH-1:0] stall_q;
	logic                   demand_q;
	logic [PORT_CYCLE_WIDTH-1:0] ready_q;

	// combinational helpers
	logic                   in_window, hit_start, hit_stop, hit_seed;
	logic [KIND_WIDTH-1:0]  kind_dec;
	logic [GCOST_WIDTH-1:0] cost_eff;
	logic                   rem_ge;
	logic [CAP_WIDTH:0]     held_sum;
	logic                   rd_err, rd_demand;
	logic [CYCLE_WIDTH-1:0] fwd_diff, back_diff, ready_n;
	logic [STALL_WIDTH:0]   back_sum;
	logic [STALL_WIDTH-1:0] stall_n;

	// a zero generation cost counts as one cycle
	assign cost_eff = (gcost_q == '0) ? GCOST_WIDTH'(1) : gcost_q;

	// address decode of the latched access
	always_comb begin
		in_window = (addr_q >= win_start_q) && (addr_q < win_end_q);
		hit_start = (addr_q == start_addr_q);
		hit_stop  = (addr_q == stop_addr_q);
		hit_seed  = (addr_q == seed_reg_q);
		if ((cap_q == '0) || !(in_window || hit_start || hit_stop || hit_seed)) begin
			kind_dec = KIND_ERROR;
		end else if (act_q == ACTION_READ) begin
			kind_dec = in_window ? KIND_DATA_READ : KIND_REG_READ;
		end else if (hit_start) begin
			kind_dec = KIND_START;
		end else if (hit_stop) begin
			kind_dec = KIND_STOP;
		end else if (hit_seed) begin
			kind_dec = KIND_SEED;
		end else begin
			kind_dec = KIND_ERROR;
		end
	end

	assign status.kind     = kind_dec;
	assign status.catch_up = running_q && !pause_q;
	assign status.div_skip = (elapsed_q >= CYCLE_WIDTH'(lim_q));

	// one restoring division step
	assign rem_ge   = (rem_q >= dsr_q);
	assign held_sum = {1'b0, held_q} + {1'b0, n_q};

	// data read: empty fifo handling and stall measurement
	always_comb begin
		rd_err    = (held_q == '0) && (!running_q || pause_q);
		rd_demand = (held_q == '0) && !rd_err;
		fwd_diff  = now_q - lgc_q;
		back_diff = lgc_q - now_q;
		ready_n   = lgc_q + CYCLE_WIDTH'(cost_eff);
		back_sum  = {1'b0, back_diff[STALL_WIDTH-1:0]} + {1'b0, cost_eff};
		if (now_q >= lgc_q) begin
			stall_n = cost_eff - fwd_diff[STALL_WIDTH-1:0];
		end else if ((back_diff >= CYCLE_WIDTH'({STALL_WIDTH{1'b1}})) || back_sum[STALL_WIDTH]) begin
			stall_n = '1;
		end else begin
			stall_n = back_sum[STALL_WIDTH-1:0];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_addr_q <= RST_START_ADDRESS;
			stop_addr_q  <= RST_STOP_ADDRESS;
			seed_reg_q   <= RST_SEED_ADDRESS;
			win_start_q  <= RST_WINDOW_START;
			win_end_q    <= RST_WINDOW_END;
			cap_q        <= RST_FIFO_CAPACITY;
			gcost_q      <= RST_GENERATE_COST;
			acost_q      <= RST_ACCESS_COST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_ADDRESS: start_addr_q <= cfg_data[ADDR_WIDTH-1:0];
				REG_STOP_ADDRESS:  stop_addr_q  <= cfg_data[ADDR_WIDTH-1:0];
				REG_SEED_ADDRESS:  seed_reg_q   <= cfg_data[ADDR_WIDTH-1:0];
				REG_WINDOW_START:  win_start_q  <= cfg_data[ADDR_WIDTH-1:0];
				REG_WINDOW_END:    win_end_q    <= cfg_data[ADDR_WIDTH-1:0];
				REG_FIFO_CAPACITY: cap_q        <= cfg_data[CAP_WIDTH-1:0];
				REG_GENERATE_COST: gcost_q      <= cfg_data[GCOST_WIDTH-1:0];
				REG_ACCESS_COST:   acost_q      <= cfg_data[ACOST_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// generator state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q    <= '0;
			lgc_q     <= '0;
			running_q <= 1'b0;
			pause_q   <= 1'b0;
		end else if (cmd.decode) begin
			case (kind_dec)
				KIND_START: begin
					if (!running_q) begin
						running_q <= 1'b1;
						pause_q   <= 1'b0;
						lgc_q     <= now_q;
					end
				end
				KIND_STOP: begin
					running_q <= 1'b0;
					pause_q   <= 1'b0;
					held_q    <= '0;
				end
				default: ;
			endcase
		end else if (cmd.add) begin
			// commit the catch-up
			lgc_q   <= lgc_q + CYCLE_WIDTH'(nprod_q);
			held_q  <= held_sum[CAP_WIDTH-1:0];
			pause_q <= (held_sum >= {1'b0, cap_q});
		end else if (cmd.read) begin
			if (rd_demand) begin
				lgc_q  <= ready_n;
				held_q <= '0;
			end else if (!rd_err) begin
				held_q <= held_q - 1'b1;
			end
		end else if (cmd.fix) begin
			// read freed a slot in a full fifo: restart from the end of the read
			if (fix_q) begin
				lgc_q   <= now_q + CYCLE_WIDTH'(stall_q);
				pause_q <= (held_q >= cap_q);
			end
		end
	end

	// access latch, divider and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= request.action;
			addr_q <= request.address;
			now_q  <= CYCLE_WIDTH'(request.now_cycle);
		end
		if (cmd.decode) begin
			kind_q   <= kind_dec;
			cost_q   <= (kind_dec == KIND_ERROR) ? '0 : acost_q;
			stall_q  <= '0;
			demand_q <= 1'b0;
			ready_q  <= '0;
			fix_q    <= 1'b0;
			room_q   <= (cap_q > held_q) ? (cap_q - held_q) : '0;
		end
		if (cmd.prep) begin
			elapsed_q <= (now_q >= lgc_q) ? (now_q - lgc_q) : '0;
			lim_q     <= PROD_WIDTH'(room_q) * PROD_WIDTH'(cost_eff);
		end
		// a full-room catch-up needs no division
		if (cmd.cmp) begin
			if (status.div_skip) begin
				n_q <= room_q;
			end else begin
				n_q   <= '0;
				rem_q <= elapsed_q[PROD_WIDTH-1:0];
				dsr_q <= PROD_WIDTH'(cost_eff) << (QUO_WIDTH - 1);
			end
		end
		if (cmd.div_step) begin
			if (rem_ge) begin
				rem_q <= rem_q - dsr_q;
			end
			n_q   <= {n_q[QUO_WIDTH-2:0], rem_ge};
			dsr_q <= dsr_q >> 1;
		end
		if (cmd.mul) begin
			nprod_q <= PROD_WIDTH'(n_q) * PROD_WIDTH'(cost_eff);
		end
		if (cmd.read) begin
			if (rd_err) begin
				kind_q <= KIND_ERROR;
				cost_q <= '0;
				fix_q  <= 1'b0;
			end else if (rd_demand) begin
				stall_q  <= stall_n;
				demand_q <= 1'b1;
				ready_q  <= PORT_CYCLE_WIDTH'(ready_n);
				fix_q    <= (cap_q == CAP_WIDTH'(1));
			end else begin
				fix_q <= pause_q;
			end
		end
	end

	always_comb begin
		result.kind                = kind_q;
		result.cost_cycles         = cost_q;
		result.wait_cycles         = stall_q;
		result.generated_on_demand = demand_q;
		result.ready_at_cycle      = ready_q;
	end

	`GFTD_ASSERT_IMP(a_pause_running, pause_q, running_q, "fifo paused while generator stopped")
	`GFTD_ASSERT_NXT(a_demand_stalls, cmd.read, !demand_q || (stall_q != '0), "on-demand read without stall")
	`GFTD_ASSERT_NXT(a_error_free, cmd.read, (kind_q != KIND_ERROR) || (cost_q == '0), "error result carries a cost")

endmodule

FILE: hdl/generator_fifo_timing_device.sv
// ----------------------------------------------------------------------------
// generator_fifo_timing_device
// timing model of a fifo-filling generator behind memory-mapped registers
// ----------------------------------------------------------------------------
// usage:
// - a bus access is presented on request and taken at a clock edge where start
//   is high and busy is low; each access gives exactly one result
// - the result appears on result for one cycle with result_valid high; there
//   is no back-pressure, the receiver takes it in that cycle
// - an accepted access is decoded, then register accesses and errors strobe;
//   a data read reads and fixes up first, and with the generator running and
//   not paused it catches up before that: prepare, compare, divide, mul, add
// - the catch-up division is a restoring divider retiring one quotient bit per
//   cycle; it is skipped when the catch-up fills the fifo
// - a new access can be taken in the cycle its predecessor's result is
//   strobed
// - configuration is written through cfg_we, cfg_index and cfg_data while no
//   access is in flight; writes take effect at the next edge
// - reset clears the generator state and loads the register defaults; the
//   device is disabled until a non-zero fifo capacity is written
// ----------------------------------------------------------------------------
module generator_fifo_timing_device import gftd_pkg::*; #(
	parameter int CYCLE_WIDTH = CYCLE_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  request_t                  request,
	output logic                      result_valid,
	output result_t                   result,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	// sequencer
	gftd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.result_valid (result_valid),
		.status       (status),
		.cmd          (cmd)
	);

	// registers, divider and result
	gftd_datapath #(
		.CYCLE_WIDTH (CYCLE_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.request   (request),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - generator fifo timing device testbench
// drives bus accesses and register writes into the device, predicts each
// timing result from a cycle-level model of the generator and its fifo, and
// checks every strobed result field by field, in order
// ----------------------------------------------------------------------------

import gftd_pkg::*;

// predicts the timing result of each access and checks the strobed results
class access_timing_scoreboard;

	localparam longint unsigned CYCLE_MASK = (64'd1 << PORT_CYCLE_WIDTH) - 1;

	// register copies
	logic [ADDR_WIDTH-1:0]  start_addr, stop_addr, seed_reg, win_lo, win_hi;
	logic [CAP_WIDTH-1:0]   capacity;
	logic [GCOST_WIDTH-1:0] gcost;
	logic [ACOST_WIDTH-1:0] acc_cost;

	// generator state
	int unsigned     held;
	longint unsigned last_gen;
	bit              running;
	bit              paused;

	result_t pending[$];
	int      failures;

	function new();
		start_addr = RST_START_ADDRESS;
		stop_addr  = RST_STOP_ADDRESS;
		seed_reg   = RST_SEED_ADDRESS;
		win_lo     = RST_WINDOW_START;
		win_hi     = RST_WINDOW_END;
		capacity   = RST_FIFO_CAPACITY;
		gcost      = RST_GENERATE_COST;
		acc_cost   = RST_ACCESS_COST;
		held       = 0;
		last_gen   = 0;
		running    = 1'b0;
		paused     = 1'b0;
		failures   = 0;
	endfunction

	function void write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] d);
		case (idx)
			REG_START_ADDRESS: start_addr = d;
			REG_STOP_ADDRESS:  stop_addr  = d;
			REG_SEED_ADDRESS:  seed_reg   = d;
			REG_WINDOW_START:  win_lo     = d;
			REG_WINDOW_END:    win_hi     = d;
			REG_FIFO_CAPACITY: capacity   = d[CAP_WIDTH-1:0];
			REG_GENERATE_COST: gcost      = d[GCOST_WIDTH-1:0];
			REG_ACCESS_COST:   acc_cost   = d[ACOST_WIDTH-1:0];
			default: ;
		endcase
	endfunction

	// a zero cost counts as one cycle
	function longint unsigned element_cost();
		return (gcost == 0) ? 64'd1 : 64'(gcost);
	endfunction

	// add the elements generated since the last one, up to the capacity
	function void catch_up(longint unsigned now);
		longint unsigned c, elapsed, q, room, n;
		if (!running || paused)
			return;
		c = element_cost();
		elapsed = (now >= last_gen) ? now - last_gen : 0;
		q = elapsed / c;
		room = (capacity > held) ? 64'(capacity) - held : 0;
		n = (q < room) ? q : room;
		last_gen = (last_gen + n * c) & CYCLE_MASK;
		held += n;
		if (held >= capacity)
			paused = 1'b1;
	endfunction

	// work out the result of one accepted transfer
	function void note_access(request_t rq);
		result_t         r;
		longint unsigned now, c, d, stall, ready;
		bit              in_win, is_ctrl, demand, ok;
		now = rq.now_cycle;
		in_win = (rq.address >= win_lo) && (rq.address < win_hi);
		is_ctrl = (rq.address == start_addr) || (rq.address == stop_addr) ||
			(rq.address == seed_reg);
		r = '0;
		r.kind = KIND_ERROR;
		if (capacity != 0 && (in_win || is_ctrl)) begin
			if (rq.action == ACTION_READ && !in_win) begin
				r.kind = KIND_REG_READ;
				r.cost_cycles = acc_cost;
			end else if (rq.action == ACTION_READ) begin
				catch_up(now);
				stall = 0;
				ready = 0;
				demand = 1'b0;
				ok = 1'b1;
				// empty fifo: wait for the next element, if one is coming
				if (held == 0) begin
					if (!running || paused) begin
						ok = 1'b0;
					end else begin
						c = element_cost();
						if (now >= last_gen) begin
							stall = c - (now - last_gen);
						end else begin
							d = last_gen - now;
							stall = (d >= 64'hFFFF) ? 64'hFFFF : d + c;
							if (stall > 64'hFFFF)
								stall = 64'hFFFF;
						end
						ready = (last_gen + c) & CYCLE_MASK;
						demand = 1'b1;
						last_gen = ready;
						held = 1;
						if (held >= capacity)
							paused = 1'b1;
					end
				end
				if (ok) begin
					held--;
					// a pop from a full fifo restarts generation at the end of the read
					if (paused) begin
						paused = 1'b0;
						last_gen = (now + stall) & CYCLE_MASK;
						catch_up(last_gen);
					end
					r.kind = KIND_DATA_READ;
					r.cost_cycles = acc_cost;
					r.wait_cycles = stall[STALL_WIDTH-1:0];
					r.generated_on_demand = demand;
					r.ready_at_cycle = ready[PORT_CYCLE_WIDTH-1:0];
				end
			end else if (rq.address == start_addr) begin
				if (!running) begin
					running = 1'b1;
					paused = 1'b0;
					last_gen = now;
				end
				r.kind = KIND_START;
				r.cost_cycles = acc_cost;
			end else if (rq.address == stop_addr) begin
				running = 1'b0;
				paused = 1'b0;
				held = 0;
				r.kind = KIND_STOP;
				r.cost_cycles = acc_cost;
			end else if (rq.address == seed_reg) begin
				r.kind = KIND_SEED;
				r.cost_cycles = acc_cost;
			end
		end
		pending.insert(pending.size(), r);
	endfunction

	function bit field_ok(string name, longint unsigned want, longint unsigned seen);
		if (want == seen)
			return 1'b1;
		$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, seen);
		return 1'b0;
	endfunction

	// compare one strobed result with the oldest prediction
	function void check_timing(result_t got);
		result_t want;
		bit      ok;
		if (pending.size() == 0) begin
			failures++;
			$display("%0t: unexpected result, expected none actual %h", $time, got);
			return;
		end
		want = pending.pop_front();
		ok = field_ok("kind", want.kind, got.kind);
		ok &= field_ok("cost_cycles", want.cost_cycles, got.cost_cycles);
		ok &= field_ok("wait_cycles", want.wait_cycles, got.wait_cycles);
		ok &= field_ok("generated_on_demand", want.generated_on_demand,
			got.generated_on_demand);
		ok &= field_ok("ready_at_cycle", want.ready_at_cycle, got.ready_at_cycle);
		if (!ok)
			failures++;
	endfunction

endclass

module tb;

	localparam longint unsigned CYCLE_MASK = (64'd1 << PORT_CYCLE_WIDTH) - 1;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	request_t                  request = '0;
	logic                      result_valid;
	result_t                   result;
	logic                      cfg_we = 1'b0;
	logic [CFG_IDX_WIDTH-1:0]  cfg_index = '0;
	logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

	access_timing_scoreboard timing_sb;

	logic [CFG_DATA_WIDTH-1:0] setting [8];
	longint unsigned           clock_now;
	int                        sent = 0;

	generator_fifo_timing_device DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 0;
	end

	// result monitor, one transfer per strobe
	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1)
			timing_sb.check_timing(result);
	end

	// run limit
	initial begin
		#5_000_000;
		$display("tb: FAIL");
		$finish;
	end

	// present one access and wait for its transfer
	task automatic send_access(input logic act, input logic [ADDR_WIDTH-1:0] addr,
			input longint unsigned now);
		request_t rq;
		bit       calm;
		rq.action = act;
		rq.address = addr;
		rq.now_cycle = now[PORT_CYCLE_WIDTH-1:0];
		calm = (sent >= 700) && (sent < 1000);
		while (!calm && $urandom_range(99) < 10) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		request <= rq;
		do @(posedge clk); while (busy !== 1'b0);
		timing_sb.note_access(rq);
		sent++;
	endtask

	// let every outstanding result drain, then a little extra
	task automatic settle();
		start <= 1'b0;
		while (timing_sb.pending.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// write every register from the setting table
	task automatic apply_settings();
		for (int i = 0; i <= int'(REG_ACCESS_COST); i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_WIDTH'(i);
			cfg_data <= setting[i];
			@(posedge clk);
			timing_sb.write_reg(CFG_IDX_WIDTH'(i), setting[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// control address near or inside the window, or anywhere
	function automatic logic [ADDR_WIDTH-1:0] near_window();
		logic [ADDR_WIDTH-1:0] lo, hi;
		lo = setting[REG_WINDOW_START];
		hi = setting[REG_WINDOW_END];
		case ($urandom_range(3))
			0, 1: return hi + $urandom_range(0, 7);
			2: return lo + $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	task automatic pick_settings(input int phase);
		logic [ADDR_WIDTH-1:0] lo;
		int                    span;
		lo = $urandom;
		span = $urandom_range(1, 64);
		setting[REG_WINDOW_START] = lo;
		setting[REG_WINDOW_END] = lo + span;
		setting[REG_START_ADDRESS] = near_window();
		setting[REG_STOP_ADDRESS] = near_window();
		setting[REG_SEED_ADDRESS] = near_window();
		// window at the top of the map
		if (phase == 5) begin
			setting[REG_WINDOW_START] = 32'hFFFF_FFC0;
			setting[REG_WINDOW_END] = 32'hFFFF_FFFF;
			setting[REG_START_ADDRESS] = 32'hFFFF_FFFF;
			setting[REG_STOP_ADDRESS] = 32'h0;
		end
		// window at the bottom, start and stop registers at its foot, seed register just past its end
		if (phase == 6) begin
			setting[REG_WINDOW_START] = 32'h0;
			setting[REG_WINDOW_END] = span;
			setting[REG_START_ADDRESS] = 32'h0;
			setting[REG_STOP_ADDRESS] = 32'h1;
			setting[REG_SEED_ADDRESS] = span;
		end
		case (phase % 5)
			0: setting[REG_FIFO_CAPACITY] = $urandom_range(1, 4);
			1: setting[REG_FIFO_CAPACITY] = $urandom_range(1, 16);
			2: setting[REG_FIFO_CAPACITY] = (phase == 2) ? 65535 : $urandom_range(1, 65535);
			3: setting[REG_FIFO_CAPACITY] = 1;
			default: setting[REG_FIFO_CAPACITY] = $urandom_range(2, 8);
		endcase
		if (phase == 7)
			setting[REG_FIFO_CAPACITY] = 0;
		if (phase == 1)
			setting[REG_GENERATE_COST] = 0;
		else if (phase == 3)
			setting[REG_GENERATE_COST] = 65535;
		else if (phase == 8)
			setting[REG_GENERATE_COST] = $urandom_range(0, 65535);
		else
			setting[REG_GENERATE_COST] = $urandom_range(1, 24);
		if (phase == 0)
			setting[REG_ACCESS_COST] = 0;
		else if (phase == 4)
			setting[REG_ACCESS_COST] = 255;
		else
			setting[REG_ACCESS_COST] = $urandom_range(0, 255);
	endtask

	// advance the processor cycle, mostly forward in small steps
	task automatic next_now();
		longint unsigned c;
		int              p;
		c = (setting[REG_GENERATE_COST][GCOST_WIDTH-1:0] == 0) ? 1 :
			setting[REG_GENERATE_COST][GCOST_WIDTH-1:0];
		p = $urandom_range(99);
		if (p < 70)
			clock_now += $urandom_range(0, 3 * c + 2);
		else if (p < 80)
			clock_now += $urandom_range(0, 3);
		else if (p < 88)
			clock_now -= $urandom_range(1, 2 * c + 5);
		else if (p < 95)
			clock_now += ({32'h0, $urandom} >> $urandom_range(0, 31));
		else
			clock_now = {$urandom, $urandom};
		clock_now &= CYCLE_MASK;
	endtask

	// choose an access, weighted towards data reads on a running generator
	task automatic pick_access(output logic act, output logic [ADDR_WIDTH-1:0] addr);
		logic [ADDR_WIDTH-1:0] lo, hi;
		longint unsigned       span;
		int                    p;
		lo = setting[REG_WINDOW_START];
		hi = setting[REG_WINDOW_END];
		span = (hi > lo) ? hi - lo : 0;
		p = $urandom_range(99);
		act = ACTION_READ;
		if (p < 50 || p >= 92) begin
			addr = (span != 0) ? lo + ({32'h0, $urandom} % span) : $urandom;
		end else if (p < 60) begin
			act = ACTION_WRITE;
			addr = setting[REG_START_ADDRESS];
		end else if (p < 64) begin
			act = ACTION_WRITE;
			addr = setting[REG_STOP_ADDRESS];
		end else if (p < 68) begin
			act = ACTION_WRITE;
			addr = setting[REG_SEED_ADDRESS];
		end else if (p < 74) begin
			case ($urandom_range(2))
				0: addr = setting[REG_START_ADDRESS];
				1: addr = setting[REG_STOP_ADDRESS];
				default: addr = setting[REG_SEED_ADDRESS];
			endcase
		end else if (p < 79) begin
			act = ACTION_WRITE;
			addr = (span != 0) ? lo + ({32'h0, $urandom} % span) : lo;
		end else if (p < 85) begin
			act = $urandom_range(1);
			addr = $urandom;
		end else begin
			act = $urandom_range(1);
			case ($urandom_range(2))
				0: addr = lo - 1;
				1: addr = hi;
				default: addr = hi - 1;
			endcase
		end
	endtask

	initial begin
		logic                  act;
		logic [ADDR_WIDTH-1:0] addr;
		timing_sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// device disabled by the reset capacity of zero
		send_access(ACTION_READ, 32'd16, 5);
		send_access(ACTION_WRITE, 32'd0, 6);

		// small fifo, control registers outside the window
		settle();
		setting[REG_START_ADDRESS] = 32'h100;
		setting[REG_STOP_ADDRESS] = 32'h104;
		setting[REG_SEED_ADDRESS] = 32'h108;
		setting[REG_WINDOW_START] = 32'h200;
		setting[REG_WINDOW_END] = 32'h300;
		setting[REG_FIFO_CAPACITY] = 2;
		setting[REG_GENERATE_COST] = 10;
		setting[REG_ACCESS_COST] = 255;
		apply_settings();
		send_access(ACTION_READ, 32'h100, 900);
		send_access(ACTION_READ, 32'h250, 900);
		send_access(ACTION_WRITE, 32'h200, 901);
		send_access(ACTION_READ, 32'hFFFF_FFFF, 901);
		send_access(ACTION_WRITE, 32'h108, 902);
		send_access(ACTION_WRITE, 32'h100, 1000);
		send_access(ACTION_WRITE, 32'h100, 1005);
		send_access(ACTION_READ, 32'h200, 1003);
		send_access(ACTION_READ, 32'h2FF, 1100);
		send_access(ACTION_READ, 32'h200, 1095);
		send_access(ACTION_READ, 32'h200, 1096);
		send_access(ACTION_WRITE, 32'h104, 1200);
		send_access(ACTION_READ, 32'h200, 1300);

		// stop register in a window at address zero, zero costs, cycle wrap
		settle();
		setting[REG_START_ADDRESS] = 32'hFFFF_FFFF;
		setting[REG_STOP_ADDRESS] = 32'h0;
		setting[REG_SEED_ADDRESS] = 32'h10;
		setting[REG_WINDOW_START] = 32'h0;
		setting[REG_WINDOW_END] = 32'h10;
		setting[REG_FIFO_CAPACITY] = 65535;
		setting[REG_GENERATE_COST] = 0;
		setting[REG_ACCESS_COST] = 0;
		apply_settings();
		send_access(ACTION_WRITE, 32'h0, 7);
		send_access(ACTION_WRITE, 32'hFFFF_FFFF, CYCLE_MASK - 2);
		send_access(ACTION_READ, 32'h5, CYCLE_MASK);
		send_access(ACTION_READ, 32'hFFFF_FFFF, 0);
		send_access(ACTION_READ, 32'h5, 0);
		send_access(ACTION_READ, 32'h5, 0);
		send_access(ACTION_READ, 32'h5, 64'h8000_0000_0000);

		// capacity lowered under a full fifo
		settle();
		setting[REG_FIFO_CAPACITY] = 3;
		setting[REG_GENERATE_COST] = 40;
		setting[REG_ACCESS_COST] = 8'h5A;
		apply_settings();
		send_access(ACTION_READ, 32'h5, 64'h8000_0000_1000);
		send_access(ACTION_WRITE, 32'h10, 64'h8000_0000_1001);

		// random phases, each with its own register setting
		for (int p = 0; p < 10; p++) begin
			settle();
			pick_settings(p);
			apply_settings();
			if (p == 9)
				clock_now = CYCLE_MASK - $urandom_range(0, 5000);
			else
				clock_now = {$urandom, $urandom} & CYCLE_MASK;
			for (int k = 0; k < ((p == 7) ? 20 : 210); k++) begin
				next_now();
				pick_access(act, addr);
				send_access(act, addr, clock_now);
			end
		end

		settle();
		if (timing_sb.failures == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
